FILE: rtl/bpf_pkg.sv
// Shared types for the bubble particle force step block.
// Used by bpf_iter_unit and bubble_particle_force_step; depends on nothing.
package bpf_pkg;

  // Operations of the shared iterative unit.
  typedef enum logic [2:0] {
    OP_MUL  = 3'b001,
    OP_DIV  = 3'b010,
    OP_SQRT = 3'b100
  } op_e;

  typedef struct packed {
    logic start;
    op_e  op;
  } unit_req_t;

  typedef struct packed {
    logic done;
    logic busy;
  } unit_rsp_t;

  // Sequencer states, one-hot.
  typedef enum logic [15:0] {
    ST_IDLE  = 16'h0001,
    ST_SQX   = 16'h0002,
    ST_SQY   = 16'h0004,
    ST_ROOT  = 16'h0008,
    ST_RATIO = 16'h0010,
    ST_R2    = 16'h0020,
    ST_R3    = 16'h0040,
    ST_PXM   = 16'h0080,
    ST_PXD   = 16'h0100,
    ST_PYM   = 16'h0200,
    ST_PYD   = 16'h0400,
    ST_DAMP  = 16'h0800,
    ST_VEL   = 16'h1000,
    ST_PRAD  = 16'h2000,
    ST_POS   = 16'h4000,
    ST_OUT   = 16'h8000
  } state_e;

endpackage

FILE: rtl/bubble_particle_force_step.sv
// Top level of the bubble particle force step: neighbor force accumulation and
// run-end velocity/position update. Depends on bpf_pkg and bpf_iter_unit.
//
//  Channel  | Direction | Transaction
//  s_axis   | in        | one neighbor item; tuser = nbr_is_self, tlast = last_nbr
//  m_axis   | out       | updated particle state, one per run
//  cfg      | in        | register write: 0 step size, 1 damping, 2 position_limit
//
// The sequencer issues one unit operation at a time. A coincident neighbor stops
// after the square root, and a self neighbor that does not end the run issues
// none. The run end adds eight multiplies and then loads the result.
// Reset clears the force sums and the registers to their defaults.
// A waiting result holds the next run's result in the output state, and no input
// is taken meanwhile.
module bubble_particle_force_step #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // self_pos_x, self_pos_y, self_vel_x, self_vel_y, self_radius, nbr_pos_x,
  // nbr_pos_y, nbr_radius, two zero bits
  input  logic [255:0] s_axis_tdata,
  // nbr_is_self
  input  logic         s_axis_tuser,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // new_pos_x, new_pos_y, new_vel_x, new_vel_y
  output logic [127:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [30:0]  cfg_data_i
);
  import bpf_pkg::*;

  localparam logic [1:0] REG_TS   = 2'd0;
  localparam logic [1:0] REG_DAMP = 2'd1;
  localparam logic [1:0] REG_LIM  = 2'd2;

  localparam logic [63:0] ONE      = 64'd1 << FRAC_BITS;
  localparam logic [63:0] EPS_Q    = (ONE + 64'd50000) / 64'd100000;
  localparam logic [63:0] R_LIM    = 64'd3 * (ONE >> 1);
  localparam logic [30:0] TS_RST   = 31'((ONE * 64'd2) / 64'd10);
  localparam logic [30:0] DAMP_RST = 31'((ONE * 64'd38429 + 64'd9999) / 64'd10000);
  localparam logic [30:0] LIM_RST  = 31'(ONE * 64'd5);
  localparam logic [96:0] BIG_LIM  = 97'd1 << 62;

  state_e state_q, state_d;
  logic   issued_q, issued_d, axis_q, axis_d;

  logic [31:0] sx_q, sy_q, vx_q, vy_q, nx_q, ny_q;
  logic [30:0] srad_q, nrad_q;
  logic        self_q, last_q;
  logic [31:0] sx_d, sy_d, vx_d, vy_d, nx_d, ny_d;
  logic [30:0] srad_d, nrad_d;
  logic        self_d, last_d;

  logic [63:0] ssum_q, ssum_d, pm_q, pm_d;
  logic [31:0] ls_q, ls_d, r_q, r_d, r2_q, r2_d, r3_q, r3_d, px_q, px_d;
  logic signed [39:0] fsx_q, fsx_d, fsy_q, fsy_d;
  logic signed [64:0] t_q, t_d;
  logic signed [31:0] vn_q, vn_d;
  logic signed [63:0] m3_q, m3_d;
  logic [31:0] npx_q, npx_d, npy_q, npy_d, nvx_q, nvx_d, nvy_q, nvy_d;
  logic [127:0] out_q, out_d;
  logic         out_valid_q, out_valid_d;
  logic [30:0]  ts_q, damp_q, lim_q;

  unit_req_t   req;
  unit_rsp_t   rsp;
  logic [63:0] op_a, op_b;
  logic [95:0] res;

  bpf_iter_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .a_i    (op_a),
    .b_i    (op_b),
    .rsp_o  (rsp),
    .res_o  (res)
  );

  // Geometry of the current neighbor.
  logic signed [32:0] dx, dy;
  logic [32:0] ax_raw, ay_raw;
  logic [31:0] ax, ay, li_raw, li;
  logic        scaled;

  always_comb begin
    dx     = {sx_q[31], sx_q} - {nx_q[31], nx_q};
    dy     = {sy_q[31], sy_q} - {ny_q[31], ny_q};
    ax_raw = dx[32] ? 33'(-dx) : 33'(dx);
    ay_raw = dy[32] ? 33'(-dy) : 33'(dy);
    scaled = ax_raw[32] | ax_raw[31] | ay_raw[32] | ay_raw[31];
    ax     = scaled ? ax_raw[32:1] : ax_raw[31:0];
    ay     = scaled ? ay_raw[32:1] : ay_raw[31:0];
    li_raw = {1'b0, srad_q} + {1'b0, nrad_q};
    li     = scaled ? {1'b0, li_raw[31:1]} : li_raw;
  end

  // Cubic force profile: floor((10*r3 - 19*r2 + 9) / 8).
  logic [34:0]        r2e, r3e, fnum_u;
  logic signed [34:0] fnum, fval;
  logic               fneg;
  logic [31:0]        fm;

  always_comb begin
    r2e    = {3'd0, r2_q};
    r3e    = {3'd0, r3_q};
    fnum_u = (r3e << 3) + (r3e << 1) - ((r2e << 4) + (r2e << 1) + r2e)
             + 35'(ONE * 64'd9);
    fnum   = signed'(fnum_u);
    fval   = fnum >>> 3;
    fneg   = fnum[34];
    fm     = fneg ? 32'(-fval) : 32'(fval);
  end

  // Operand for the fixed-point products at run end.
  logic signed [31:0] cur_v, cur_p;
  logic signed [39:0] cur_fs;
  logic signed [64:0] sval;
  logic               mneg;
  logic [63:0]        mmag;

  always_comb begin
    cur_v  = axis_q ? signed'(vy_q) : signed'(vx_q);
    cur_p  = axis_q ? signed'(sy_q) : signed'(sx_q);
    cur_fs = axis_q ? fsy_q : fsx_q;
    case (state_q)
      ST_VEL:  sval = t_q;
      ST_PRAD: sval = 65'(vn_q);
      ST_POS:  sval = 65'(m3_q);
      default: sval = 65'(cur_v);
    endcase
    mneg = sval[64];
    mmag = mneg ? 64'(-sval) : sval[63:0];
  end

  // floor(a * b / 2^F) with magnitude saturated at 2^62.
  logic [96:0]        prod_r, prod_sh;
  logic [62:0]        mq_mag;
  logic signed [63:0] mq;

  always_comb begin
    prod_r  = {1'b0, res} + (mneg ? 97'(ONE - 64'd1) : 97'd0);
    prod_sh = prod_r >> FRAC_BITS;
    mq_mag  = (prod_sh > BIG_LIM) ? BIG_LIM[62:0] : prod_sh[62:0];
    mq      = mneg ? -signed'({1'b0, mq_mag}) : signed'({1'b0, mq_mag});
  end

  logic compute_st, push, out_load;

  // Unit operand selection.
  always_comb begin
    req.start = compute_st && !issued_q;
    req.op    = OP_MUL;
    op_a      = '0;
    op_b      = '0;
    case (state_q)
      ST_SQX: begin
        op_a = {32'd0, ax};
        op_b = {32'd0, ax};
      end
      ST_SQY: begin
        op_a = {32'd0, ay};
        op_b = {32'd0, ay};
      end
      ST_ROOT: begin
        req.op = OP_SQRT;
        op_a   = ssum_q;
      end
      ST_RATIO: begin
        req.op = OP_DIV;
        op_a   = {32'd0, ls_q} << FRAC_BITS;
        op_b   = {32'd0, li};
      end
      ST_R2: begin
        op_a = {32'd0, r_q};
        op_b = {32'd0, r_q};
      end
      ST_R3: begin
        op_a = {32'd0, r2_q};
        op_b = {32'd0, r_q};
      end
      ST_PXM: begin
        op_a = {32'd0, ax};
        op_b = {32'd0, fm};
      end
      ST_PYM: begin
        op_a = {32'd0, ay};
        op_b = {32'd0, fm};
      end
      ST_PXD, ST_PYD: begin
        req.op = OP_DIV;
        op_a   = pm_q;
        op_b   = {32'd0, ls_q};
      end
      ST_DAMP: begin
        op_a = mmag;
        op_b = {33'd0, damp_q};
      end
      ST_VEL, ST_POS: begin
        op_a = mmag;
        op_b = {33'd0, ts_q};
      end
      ST_PRAD: begin
        op_a = mmag;
        op_b = {33'd0, srad_q};
      end
      default: begin
      end
    endcase
  end

  // Saturating force accumulation, coincidence test and velocity/position sums.
  logic signed [31:0] fx_add, fy_add;
  logic signed [40:0] sumx, sumy;
  logic signed [39:0] satx, saty;
  logic signed [64:0] vsum, psum, lim_s;

  always_comb begin
    sumx = 41'(fsx_q) + 41'(fx_add);
    sumy = 41'(fsy_q) + 41'(fy_add);
    satx = (sumx[40] != sumx[39]) ? {sumx[40], {39{~sumx[40]}}} : sumx[39:0];
    saty = (sumy[40] != sumy[39]) ? {sumy[40], {39{~sumy[40]}}} : sumy[39:0];
    push = !scaled && ((res[31:0] == 32'd0) || ({32'd0, res[31:0]} < EPS_Q));
    vsum = 65'(cur_v) + 65'(mq);
    psum = 65'(cur_p) + 65'(mq);
    lim_s = signed'({34'd0, lim_q});
  end

  assign compute_st = (state_q != ST_IDLE) && (state_q != ST_OUT);
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    issued_d = issued_q;
    axis_d = axis_q;
    {sx_d, sy_d, vx_d, vy_d, nx_d, ny_d} = {sx_q, sy_q, vx_q, vy_q, nx_q, ny_q};
    {srad_d, nrad_d, self_d, last_d} = {srad_q, nrad_q, self_q, last_q};
    ssum_d = ssum_q;
    pm_d = pm_q;
    ls_d = ls_q;
    r_d = r_q;
    r2_d = r2_q;
    r3_d = r3_q;
    px_d = px_q;
    fsx_d = fsx_q;
    fsy_d = fsy_q;
    t_d = t_q;
    vn_d = vn_q;
    m3_d = m3_q;
    npx_d = npx_q;
    npy_d = npy_q;
    nvx_d = nvx_q;
    nvy_d = nvy_q;
    out_d = out_q;
    out_valid_d = out_valid_q;
    fx_add = '0;
    fy_add = '0;

    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;
    if (req.start) issued_d = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          sx_d   = s_axis_tdata[31:0];
          sy_d   = s_axis_tdata[63:32];
          vx_d   = s_axis_tdata[95:64];
          vy_d   = s_axis_tdata[127:96];
          srad_d = s_axis_tdata[158:128];
          nx_d   = s_axis_tdata[190:159];
          ny_d   = s_axis_tdata[222:191];
          nrad_d = s_axis_tdata[253:223];
          self_d = s_axis_tuser;
          last_d = s_axis_tlast;
          axis_d = 1'b0;
          if (!s_axis_tuser) state_d = ST_SQX;
          else if (s_axis_tlast) state_d = ST_DAMP;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_d       = {nvy_q, nvx_q, npy_q, npx_q};
          out_valid_d = 1'b1;
          fsx_d       = '0;
          fsy_d       = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        if (rsp.done) begin
          issued_d = 1'b0;
          case (state_q)
            ST_SQX: begin
              ssum_d  = res[63:0];
              state_d = ST_SQY;
            end
            ST_SQY: begin
              ssum_d  = ssum_q + res[63:0];
              state_d = ST_ROOT;
            end
            ST_ROOT: begin
              ls_d = res[31:0];
              if (push) begin
                fx_add  = 32'(ONE * 64'd10);
                fy_add  = 32'(ONE * 64'd10);
                fsx_d   = satx;
                fsy_d   = saty;
                state_d = last_q ? ST_DAMP : ST_IDLE;
              end else if (li == 32'd0) begin
                state_d = last_q ? ST_DAMP : ST_IDLE;
              end else begin
                state_d = ST_RATIO;
              end
            end
            ST_RATIO: begin
              r_d = res[31:0];
              if (res[63:0] >= R_LIM) state_d = last_q ? ST_DAMP : ST_IDLE;
              else state_d = ST_R2;
            end
            ST_R2: begin
              r2_d    = 32'(res[63:0] >> FRAC_BITS);
              state_d = ST_R3;
            end
            ST_R3: begin
              r3_d    = 32'(res[63:0] >> FRAC_BITS);
              state_d = ST_PXM;
            end
            ST_PXM: begin
              pm_d    = res[63:0];
              state_d = ST_PXD;
            end
            ST_PXD: begin
              px_d    = res[31:0];
              state_d = ST_PYM;
            end
            ST_PYM: begin
              pm_d    = res[63:0];
              state_d = ST_PYD;
            end
            ST_PYD: begin
              // The force points along the sign of f times the offset sign.
              fx_add  = (fneg ^ dx[32]) ? -signed'(px_q) : signed'(px_q);
              fy_add  = (fneg ^ dy[32]) ? -signed'(res[31:0]) : signed'(res[31:0]);
              fsx_d   = satx;
              fsy_d   = saty;
              state_d = last_q ? ST_DAMP : ST_IDLE;
            end
            ST_DAMP: begin
              t_d     = 65'(cur_fs) - 65'(mq);
              state_d = ST_VEL;
            end
            ST_VEL: begin
              if (vsum > 65'sh7FFFFFFF) vn_d = 32'sh7FFFFFFF;
              else if (vsum < -65'sh80000000) vn_d = 32'sh80000000;
              else vn_d = vsum[31:0];
              if (axis_q) nvy_d = vn_d;
              else nvx_d = vn_d;
              state_d = ST_PRAD;
            end
            ST_PRAD: begin
              m3_d    = mq;
              state_d = ST_POS;
            end
            ST_POS: begin
              if (psum > lim_s) begin
                if (axis_q) npy_d = 32'(lim_s);
                else npx_d = 32'(lim_s);
              end else if (psum < -lim_s) begin
                if (axis_q) npy_d = 32'(-lim_s);
                else npx_d = 32'(-lim_s);
              end else begin
                if (axis_q) npy_d = psum[31:0];
                else npx_d = psum[31:0];
              end
              axis_d  = 1'b1;
              state_d = axis_q ? ST_OUT : ST_DAMP;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issued_q    <= 1'b0;
      axis_q      <= 1'b0;
      fsx_q       <= '0;
      fsy_q       <= '0;
      out_valid_q <= 1'b0;
      ts_q        <= TS_RST;
      damp_q      <= DAMP_RST;
      lim_q       <= LIM_RST;
    end else begin
      state_q     <= state_d;
      issued_q    <= issued_d;
      axis_q      <= axis_d;
      fsx_q       <= fsx_d;
      fsy_q       <= fsy_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TS:   ts_q   <= cfg_data_i;
          REG_DAMP: damp_q <= cfg_data_i;
          REG_LIM:  lim_q  <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sx_q   <= sx_d;
    sy_q   <= sy_d;
    vx_q   <= vx_d;
    vy_q   <= vy_d;
    nx_q   <= nx_d;
    ny_q   <= ny_d;
    srad_q <= srad_d;
    nrad_q <= nrad_d;
    self_q <= self_d;
    last_q <= last_d;
    ssum_q <= ssum_d;
    pm_q   <= pm_d;
    ls_q   <= ls_d;
    r_q    <= r_d;
    r2_q   <= r2_d;
    r3_q   <= r3_d;
    px_q   <= px_d;
    t_q    <= t_d;
    vn_q   <= vn_d;
    m3_q   <= m3_d;
    npx_q  <= npx_d;
    npy_q  <= npy_d;
    nvx_q  <= nvx_d;
    nvy_q  <= nvy_d;
    out_q  <= out_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // A self neighbor never reaches the force computation.
  a_self_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQX) |-> !self_q)
    else $error("self neighbor entered force computation");

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.start |-> !rsp.busy)
    else $error("unit started while busy");

  a_done_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> issued_q)
    else $error("unit result without a pending request");

  a_sums_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (fsx_q == '0) && (fsy_q == '0) && m_axis_tvalid)
    else $error("force sums not cleared after a result");

endmodule

FILE: rtl/bpf_iter_unit.sv
// Shared iterative arithmetic unit: 64x32 shift-add multiply, 64/64 restoring
// divide and 64-bit integer square root. Depends on bpf_pkg.
module bpf_iter_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bpf_pkg::unit_req_t      req_i,
  input  logic [63:0]             a_i,
  input  logic [63:0]             b_i,
  output bpf_pkg::unit_rsp_t      rsp_o,
  output logic [95:0]             res_o
);
  import bpf_pkg::*;

  logic        busy_q, busy_d, done_q, done_d;
  op_e         op_q, op_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] wa_q, wa_d, wb_q, wb_d, d_q, d_d;
  logic [31:0] root_q, root_d;

  logic [64:0] mul_sum, div_sh, sq_rs, sq_trial;
  logic        div_ge, sq_ge;

  always_comb begin
    mul_sum  = {1'b0, wa_q} + (wb_q[0] ? {1'b0, d_q} : 65'd0);
    div_sh   = {wa_q, wb_q[63]};
    div_ge   = div_sh >= {1'b0, d_q};
    sq_rs    = {wa_q[62:0], wb_q[63:62]};
    sq_trial = {31'd0, root_q, 2'b01};
    sq_ge    = sq_rs >= sq_trial;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    wa_d   = wa_q;
    wb_d   = wb_q;
    d_d    = d_q;
    root_d = root_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      wa_d   = '0;
      root_d = '0;
      d_d    = a_i;
      wb_d   = a_i;
      cnt_d  = 7'd31;
      case (req_i.op)
        OP_MUL: begin
          wb_d = {32'd0, b_i[31:0]};
        end
        OP_DIV: begin
          d_d   = b_i;
          cnt_d = 7'd63;
        end
        OP_SQRT: begin
        end
        default: begin
        end
      endcase
    end else if (busy_q) begin
      case (op_q)
        OP_MUL: begin
          wa_d = mul_sum[64:1];
          wb_d = {32'd0, mul_sum[0], wb_q[31:1]};
        end
        OP_DIV: begin
          wa_d = div_ge ? 64'(div_sh - {1'b0, d_q}) : div_sh[63:0];
          wb_d = {wb_q[62:0], div_ge};
        end
        OP_SQRT: begin
          wa_d   = sq_ge ? 64'(sq_rs - sq_trial) : sq_rs[63:0];
          root_d = {root_q[30:0], sq_ge};
          wb_d   = {wb_q[61:0], 2'b00};
        end
        default: begin
        end
      endcase
      if (cnt_q == 7'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_MUL;
      cnt_q  <= '0;
      wa_q   <= '0;
      wb_q   <= '0;
      d_q    <= '0;
      root_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
      wa_q   <= wa_d;
      wb_q   <= wb_d;
      d_q    <= d_d;
      root_q <= root_d;
    end
  end

  always_comb begin
    case (op_q)
      OP_MUL:  res_o = {wa_q, wb_q[31:0]};
      OP_DIV:  res_o = {32'd0, wb_q};
      OP_SQRT: res_o = {64'd0, root_q};
      default: res_o = '0;
    endcase
  end

  assign rsp_o = '{done: done_q, busy: busy_q};

endmodule
